// ===== rtl/core/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and constants for the transposition table engine.
// ----------------------------------------------------------------------------
package tte_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 4;
    localparam int SCORE_W = 64;
    localparam int KIND_W  = 2;

    localparam int S_TDATA_W = 264;
    localparam int M_TDATA_W = 72;

    // stored bound kinds
    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPPER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;

    // operation select
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_STORE  = 1'b1;

    typedef struct packed {
        logic                      func;
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        logic signed [SCORE_W-1:0] score;
        logic [KIND_W-1:0]         bound_type;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [KIND_W-1:0]         kind;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                      found;
        logic signed [SCORE_W-1:0] value;
        logic                      written;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

endpackage

// ===== rtl/core/tte_ram.sv =====
// ----------------------------------------------------------------------------
// tte_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tte_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 134
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tte_probe.sv =====
// ----------------------------------------------------------------------------
// tte_probe
// Compares the resident entry against the request; decides hit, returned
// value and whether a store replaces the entry.
// ----------------------------------------------------------------------------
module tte_probe import tte_pkg::*; (
    input  item_t   item,
    input  entry_t  entry,
    output result_t result,
    output logic    replace
);

    logic key_hit;
    logic le_alpha;
    logic ge_beta;

    assign key_hit  = (entry.key == item.key) && (entry.depth >= item.depth);
    assign le_alpha = (entry.score <= item.alpha);
    assign ge_beta  = (entry.score >= item.beta);

    // depth-preferred: replace unless the resident entry is deeper
    assign replace = (item.func == FUNC_STORE) && (entry.depth <= item.depth);

    always_comb begin
        result.found   = 1'b0;
        result.value   = '0;
        result.written = replace;
        if (item.func == FUNC_LOOKUP && key_hit) begin
            case (entry.kind)
                KIND_EXACT: begin
                    result.found = 1'b1;
                    result.value = entry.score;
                end
                KIND_UPPER: begin
                    if (le_alpha) begin
                        result.found = 1'b1;
                        result.value = item.alpha;
                    end
                end
                KIND_LOWER: begin
                    if (ge_beta) begin
                        result.found = 1'b1;
                        result.value = item.beta;
                    end
                end
                default: begin
                    result.found = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/transposition_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// transposition_table_engine_core
// Direct-mapped, depth-preferred transposition table: lookups and stores
// keyed by a 64-bit position hash, one result word per request word.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+------------------------------------
//  s_      | in  | s_tvalid/s_tready  | request word, s_tuser = func
//  m_      | out | m_tvalid/m_tready  | result word: found, value, written
//
// Each word's slot is read from the single-port table in ST_IDLE, then
// compared in ST_EVAL, which writes it back for a replacing store.
// A new request is accepted in the cycle after the previous one leaves the
// compare stage; the result sits in the output register meanwhile.
// After reset the table is swept to zero, one entry per cycle, across all
// TABLE_ENTRIES (4096) entries; s_tready stays low during the sweep.
// A stalled m_ side holds the compare stage (no write-back until the
// result register is free).
// ----------------------------------------------------------------------------
module transposition_table_engine_core import tte_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [63:0] key, [67:64] depth, [131:68] alpha, [195:132] beta,
    // [259:196] score, [261:260] bound_type, [263:262] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] func
    input  logic                 s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] found, [64:1] value, [65] written, [71:66] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    item_t            item_reg;
    item_t            item_in;
    result_t          result_reg;
    logic             m_tvalid_reg, m_tvalid_next;

    logic             accept;
    logic             advance;
    logic             clr_last;

    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    entry_t           entry_rd;
    entry_t           entry_wr;
    result_t          probe_result;
    logic             probe_replace;

    // ---- request unpacking ----
    assign item_in.func       = s_tuser;
    assign item_in.key        = s_tdata[63:0];
    assign item_in.depth      = s_tdata[67:64];
    assign item_in.alpha      = s_tdata[131:68];
    assign item_in.beta       = s_tdata[195:132];
    assign item_in.score      = s_tdata[259:196];
    assign item_in.bound_type = s_tdata[261:260];

    assign accept   = s_tvalid && s_tready;
    // compare stage may complete once the result register can take a word
    assign advance  = !m_tvalid_reg || m_tready;
    assign clr_last = (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1));

    // ---- table ----
    tte_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign entry_rd = entry_t'(ram_rdata);

    // ---- compare ----
    tte_probe u_probe (
        .item    (item_reg),
        .entry   (entry_rd),
        .result  (probe_result),
        .replace (probe_replace)
    );

    assign entry_wr.key   = item_reg.key;
    assign entry_wr.depth = item_reg.depth;
    assign entry_wr.score = item_reg.score;
    assign entry_wr.kind  = item_reg.bound_type;

    // ---- state machine: next state ----
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (advance) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ---- state machine: outputs ----
    always_comb begin
        s_tready  = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = item_reg.key[IDX_W-1:0];
        ram_wdata = ENTRY_W'(entry_wr);
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_re   = s_tvalid;
                ram_addr = item_in.key[IDX_W-1:0];
            end
            ST_EVAL: begin
                ram_we = advance && probe_replace;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---- clear sweep counter ----
    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (state_reg == ST_CLEAR) begin
            clr_cnt_next = clr_cnt_reg + IDX_W'(1);
        end
    end

    // ---- result register ----
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (state_reg == ST_EVAL && advance) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_in;
        end
        if (state_reg == ST_EVAL && advance) begin
            result_reg <= probe_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, result_reg.written, result_reg.value, result_reg.found};

    // ---- assertions ----
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !accept)
        else $error("request accepted during table sweep");

    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR) || (state_reg == ST_EVAL && advance))
        else $error("table write outside sweep or write-back");

    a_result_from_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_EVAL))
        else $error("result word without a completed compare");

    a_found_written_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[65]))
        else $error("found and written set together");

endmodule
